/* rtl/core/rrt_pkg.sv */
// relay registration table: shared types, constants and codes
// no dependencies
package rrt_pkg;

    localparam int MAX_NODES        = 16;
    localparam int MAX_BEACON_SLOTS = 16;
    localparam int IDX_W            = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W            = $clog2(MAX_NODES + 1);

    localparam logic [7:0] NO_SLOT     = 8'hFF;
    localparam logic       KIND_REQ    = 1'b0;
    localparam logic       KIND_SWEEP  = 1'b1;
    localparam logic       STATUS_OK   = 1'b0;
    localparam logic       STATUS_FULL = 1'b1;

    localparam logic [2:0] CFG_MY_NODE_ID     = 3'd0;
    localparam logic [2:0] CFG_NETWORK_ID     = 3'd1;
    localparam logic [2:0] CFG_LOCAL_STRATUM  = 3'd2;
    localparam logic [2:0] CFG_ADVERT_INT     = 3'd3;
    localparam logic [2:0] CFG_OWN_SLOT       = 3'd4;
    localparam logic [2:0] CFG_MAX_AGE        = 3'd5;
    localparam logic [2:0] CFG_TIER_MASK      = 3'd6;
    localparam logic [2:0] CFG_TIER_VALUE     = 3'd7;

    typedef struct packed {
        logic               kind;
        logic [31:0]        node_id;
        logic [7:0]         capability;
        logic signed [15:0] rssi_dbm;
        logic [31:0]        now_ms;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic        status;
        logic [31:0] dest_node;
        logic [15:0] resp_network_id;
        logic [7:0]  resp_stratum;
        logic [7:0]  resp_interval_s;
        logic [7:0]  assigned_slot;
        logic [15:0] response_seq;
        logic [4:0]  entries_left;
    } t_out;

    typedef struct packed {
        logic [31:0] my_node_id;
        logic [15:0] network_id;
        logic [7:0]  hop_depth;
        logic [7:0]  advert_interval_s;
        logic [7:0]  own_beacon_slot;
        logic [31:0] age_limit_ms;
        logic [7:0]  relay_tier_mask;
        logic [7:0]  relay_tier_value;
    } t_cfg;

    typedef struct packed {
        logic       en;
        logic [7:0] slot;
    } t_clear;

    typedef struct packed {
        logic [31:0]        node;
        logic [7:0]         capability;
        logic signed [15:0] rssi;
        logic [31:0]        last_seen;
        logic [7:0]         slot;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MISS,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_CP
    } t_state;

endpackage

/* rtl/core/rrt_ram.sv */
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/core/rrt_ctrl.sv */
// table sequencer: lookup, append, refresh and stale sweep over the entry ram
// depends on rrt_pkg and rrt_ram
module rrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rrt_pkg::t_in   i_req,
    output logic           o_busy,
    input  rrt_pkg::t_cfg  i_cfg,
    input  rrt_pkg::t_clear i_clear,
    output logic           o_strobe,
    output rrt_pkg::t_out  o_result
);
    import rrt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_next_slot, n_next_slot;
    logic [15:0]      r_seq, n_seq;
    t_in              r_req, n_req;
    logic             r_strobe, n_strobe;
    t_out             r_out, n_out;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    t_entry           mem_wdata, mem_rdata;
    logic [$bits(t_entry)-1:0] mem_rbits;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] count_dec;
    logic             hit;
    logic             more;
    logic             stale;
    logic [31:0]      age;
    logic             is_relay;
    logic             slot_free;
    logic [15:0]      seq_inc;

    rrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rbits)
    );

    assign mem_rdata = t_entry'(mem_rbits);
    assign idx_inc   = r_idx + CNT_W'(1);
    assign count_dec = r_count - CNT_W'(1);
    assign hit       = (mem_rdata.node == r_req.node_id);
    assign more      = (idx_inc < r_count);
    assign age       = r_req.now_ms - mem_rdata.last_seen;
    assign stale     = (age > i_cfg.age_limit_ms);
    assign is_relay  = ((r_req.capability & i_cfg.relay_tier_mask) == i_cfg.relay_tier_value);
    assign slot_free = (r_next_slot < 8'(MAX_BEACON_SLOTS));
    assign seq_inc   = r_seq + 16'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req.kind == KIND_SWEEP) begin
                        n_state = ST_SW_RD;
                    end else if (r_count == '0) begin
                        n_state = ST_MISS;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (hit) begin
                    n_state = ST_IDLE;
                end else if (!more) begin
                    n_state = ST_MISS;
                end
            end
            ST_MISS:   n_state = ST_IDLE;
            ST_SW_RD:  n_state = (r_idx < r_count) ? ST_SW_CHK : ST_IDLE;
            ST_SW_CHK: n_state = stale ? ST_SW_CP : ST_SW_RD;
            ST_SW_CP:  n_state = ST_SW_RD;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_count     = r_count;
        n_next_slot = r_next_slot;
        n_seq       = r_seq;
        n_req       = r_req;
        n_strobe    = 1'b0;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_idx[IDX_W-1:0];
        mem_raddr   = r_idx[IDX_W-1:0];
        mem_wdata   = mem_rdata;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_idx = '0;
                    if (i_req.kind == KIND_REQ && r_count != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                    end
                end
                if (i_clear.en) begin
                    n_count     = '0;
                    n_next_slot = i_clear.slot + 8'd1;
                end
            end
            ST_LOOK: begin
                if (hit) begin
                    mem_we              = 1'b1;
                    mem_wdata.node      = r_req.node_id;
                    mem_wdata.capability = r_req.capability;
                    mem_wdata.rssi      = r_req.rssi_dbm;
                    mem_wdata.last_seen = r_req.now_ms;
                    mem_wdata.slot      = mem_rdata.slot;
                    n_seq               = seq_inc;
                    n_strobe            = 1'b1;
                    n_out.result_kind     = KIND_REQ;
                    n_out.status          = STATUS_OK;
                    n_out.dest_node       = r_req.node_id;
                    n_out.resp_network_id = i_cfg.network_id;
                    n_out.resp_stratum    = i_cfg.hop_depth;
                    n_out.resp_interval_s = i_cfg.advert_interval_s;
                    n_out.assigned_slot   = mem_rdata.slot;
                    n_out.response_seq    = seq_inc;
                    n_out.entries_left    = 5'(r_count);
                end else if (more) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc[IDX_W-1:0];
                    n_idx     = idx_inc;
                end
            end
            ST_MISS: begin
                n_seq    = seq_inc;
                n_strobe = 1'b1;
                n_out.result_kind     = KIND_REQ;
                n_out.dest_node       = r_req.node_id;
                n_out.resp_network_id = i_cfg.network_id;
                n_out.resp_stratum    = i_cfg.hop_depth;
                n_out.resp_interval_s = i_cfg.advert_interval_s;
                n_out.response_seq    = seq_inc;
                if (r_count >= CNT_W'(MAX_NODES)) begin
                    n_out.status        = STATUS_FULL;
                    n_out.assigned_slot = NO_SLOT;
                    n_out.entries_left  = 5'(r_count);
                end else begin
                    mem_we               = 1'b1;
                    mem_waddr            = r_count[IDX_W-1:0];
                    mem_wdata.node       = r_req.node_id;
                    mem_wdata.capability = r_req.capability;
                    mem_wdata.rssi       = r_req.rssi_dbm;
                    mem_wdata.last_seen  = r_req.now_ms;
                    if (is_relay && slot_free) begin
                        mem_wdata.slot = r_next_slot;
                        n_next_slot    = r_next_slot + 8'd1;
                    end else begin
                        mem_wdata.slot = NO_SLOT;
                    end
                    n_count             = r_count + CNT_W'(1);
                    n_out.status        = STATUS_OK;
                    n_out.assigned_slot = mem_wdata.slot;
                    n_out.entries_left  = 5'(r_count + CNT_W'(1));
                end
            end
            ST_SW_RD: begin
                if (r_idx < r_count) begin
                    mem_re = 1'b1;
                end else begin
                    n_strobe = 1'b1;
                    n_out    = '0;
                    n_out.result_kind  = KIND_SWEEP;
                    n_out.entries_left = 5'(r_count);
                end
            end
            ST_SW_CHK: begin
                if (stale) begin
                    n_count   = count_dec;
                    mem_re    = 1'b1;
                    mem_raddr = count_dec[IDX_W-1:0];
                end else begin
                    n_idx = idx_inc;
                end
            end
            ST_SW_CP: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_next_slot <= 8'd1;
            r_seq       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_next_slot <= n_next_slot;
            r_seq       <= n_seq;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NODES))
        else $error("entry count beyond table size");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == ST_IDLE)
        else $error("word shown while still busy");

    a_seq_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.result_kind == KIND_REQ) |-> r_out.response_seq == r_seq)
        else $error("response sequence out of step");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SW_CP |-> $past(r_state) == ST_SW_CHK)
        else $error("sweep copy without stale check");
`endif

endmodule

/* rtl/core/relay_registration_table.sv */
// relay registration table top: configuration registers and table sequencer
// depends on rrt_pkg and rrt_ctrl
// a request scans the entries until a hit and appends on a miss; a sweep checks each entry
// one word at a time, the next start is taken in the strobe cycle
// the result strobe lasts one cycle and the receiver cannot stall it
// reset: synchronous active low; table empty, next slot 1, sequence 0, config registers 0
module relay_registration_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rrt_pkg::t_in  i_req,
    output logic          busy,
    output logic          o_strobe,
    output rrt_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import rrt_pkg::*;

    t_cfg   r_cfg;
    t_clear cfg_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MY_NODE_ID:    r_cfg.my_node_id        <= i_cfg_data;
                CFG_NETWORK_ID:    r_cfg.network_id        <= i_cfg_data[15:0];
                CFG_LOCAL_STRATUM: r_cfg.hop_depth         <= i_cfg_data[7:0];
                CFG_ADVERT_INT:    r_cfg.advert_interval_s <= i_cfg_data[7:0];
                CFG_OWN_SLOT:      r_cfg.own_beacon_slot   <= i_cfg_data[7:0];
                CFG_MAX_AGE:       r_cfg.age_limit_ms      <= i_cfg_data;
                CFG_TIER_MASK:     r_cfg.relay_tier_mask   <= i_cfg_data[7:0];
                CFG_TIER_VALUE:    r_cfg.relay_tier_value  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_clear.en   = i_cfg_we && (i_cfg_idx == CFG_OWN_SLOT);
    assign cfg_clear.slot = i_cfg_data[7:0];

    rrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .o_busy   (busy),
        .i_cfg    (r_cfg),
        .i_clear  (cfg_clear),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
